### hw/rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared definitions for the lifo stack
// sizes, command and status codes, sequencer states, storage request bundle
// ----------------------------------------------------------------------------
package stk_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;
	localparam int STAT_W = 2;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_MODIFY = 3'd3,
		CMD_DUMP   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BADPOS   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                     wr_en;
		logic [ADDR_W-1:0]        wr_addr;
		logic signed [WORD_W-1:0] wr_data;
		logic                     rd_en;
		logic [ADDR_W-1:0]        rd_addr;
	} mem_req_t;

endpackage

### hw/rtl/stk_store.sv
// ----------------------------------------------------------------------------
// stk_store: entry storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stk_store
	import stk_pkg::*;
(
	input  logic                     clk,
	input  mem_req_t                 req,
	output logic signed [WORD_W-1:0] rd_data
);

	logic signed [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

### hw/rtl/stack_with_modify_and_dump.sv
// ----------------------------------------------------------------------------
// stack_with_modify_and_dump: lifo stack of signed words with modify and dump
// push, pop, peek, modify at a position from the bottom, dump top to bottom
// ----------------------------------------------------------------------------
// results: push, modify and every error go from S_IDLE straight to S_OUT with
//   the result registered; pop and peek go through S_READ for the read port
// dump: each entry goes through S_READ and S_OUT, top to bottom, held by any output stall
// one item at a time: the next is taken only once the last result of the
//   previous one has left and the sequencer is back in S_IDLE
// reset: arst_n clears the fill count and the sequencer; entries are not cleared
module stack_with_modify_and_dump
	import stk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [WORD_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [WORD_W-1:0] data,
	output logic                     last
);

	// sequencer and control state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              dump_q, dump_d;

	// output register, holds the result until it is taken
	logic [STAT_W-1:0]        status_q, status_d;
	logic signed [WORD_W-1:0] data_q, data_d;
	logic                     last_q, last_d;

	// storage port
	mem_req_t                 mem_req;
	logic signed [WORD_W-1:0] rd_data;

	// shared compare and address logic on the fill count
	logic              is_empty;
	logic              is_full;
	logic              pos_bad;
	logic [ADDR_W-1:0] top_addr;

	assign is_empty = (fill_q == '0);
	assign is_full  = (fill_q == CNT_W'(DEPTH));
	assign pos_bad  = (CMP_W'(position) >= CMP_W'(fill_q));
	assign top_addr = ADDR_W'(fill_q - CNT_W'(1));

	stk_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			dump_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			dump_q  <= dump_d;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		status_q <= status_d;
		data_q   <= data_d;
		last_q   <= last_d;
	end

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		dump_d   = dump_q;
		status_d = status_q;
		data_d   = data_q;
		last_d   = last_q;

		mem_req         = '0;
		mem_req.wr_data = value;

		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					// error results and plain acks carry zero data
					data_d = '0;
					last_d = 1'b1;
					case (cmd)
						CMD_PUSH: begin
							if (is_full) begin
								status_d = ST_OVERFLOW;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = ADDR_W'(fill_q);
								fill_d          = fill_q + CNT_W'(1);
								status_d        = ST_OK;
							end
							state_d = S_OUT;
						end
						CMD_POP, CMD_PEEK: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
								state_d  = S_OUT;
							end else begin
								// pop drops the count now, the read still sees the word
								if (cmd == CMD_POP) begin
									fill_d = fill_q - CNT_W'(1);
								end
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = top_addr;
								idx_d           = top_addr;
								dump_d          = 1'b0;
								state_d         = S_READ;
							end
						end
						CMD_MODIFY: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else if (pos_bad) begin
								status_d = ST_BADPOS;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = ADDR_W'(position);
								status_d        = ST_OK;
							end
							state_d = S_OUT;
						end
						CMD_DUMP: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
								state_d  = S_OUT;
							end else begin
								// walk from the top entry down to the bottom
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = top_addr;
								idx_d           = top_addr;
								dump_d          = 1'b1;
								state_d         = S_READ;
							end
						end
						default: begin
							// unknown command: taken, no result
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				// registered read data is valid now
				status_d = ST_OK;
				data_d   = rd_data;
				last_d   = !dump_q || (idx_q == '0);
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (dump_q && (idx_q != '0)) begin
						// next entry down
						idx_d           = idx_q - ADDR_W'(1);
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = idx_q - ADDR_W'(1);
						state_d         = S_READ;
					end else begin
						dump_d  = 1'b0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

endmodule

### hw/rtl/stk_chk.sv
// ----------------------------------------------------------------------------
// stk_chk: port-level checks for the lifo stack
// watches the two channels of the top level, bound in below
// ----------------------------------------------------------------------------
module stk_chk
	import stk_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [CMD_W-1:0]         cmd,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [STAT_W-1:0]        status,
	input logic signed [WORD_W-1:0] data,
	input logic                     last
);

	// one item at a time: never taking input while a result is shown
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data)
			&& $stable(last))
		else $error("result changed under stall");

	// error results are single, final and carry zero data
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && (data == '0))
		else $error("error result not final or nonzero");

	// a known command always keeps the block busy until its results are out
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ((cmd == CMD_PUSH) || (cmd == CMD_POP)
			|| (cmd == CMD_PEEK) || (cmd == CMD_MODIFY) || (cmd == CMD_DUMP))
		|=> !in_ready)
		else $error("block ready right after a command");

	// the final result frees the input side
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("not ready after final result");

endmodule

bind stack_with_modify_and_dump stk_chk u_stk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.data      (data),
	.last      (last)
);
